// ===== src/path_time_allocation_macros.svh =====
// Assertion macros shared by the path time allocation RTL.
`ifndef PATH_TIME_ALLOCATION_MACROS_SVH
`define PATH_TIME_ALLOCATION_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define PTA_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("path_time_allocation check failed");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define PTA_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("path_time_allocation check failed");
`else
`define PTA_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PTA_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== src/pta_pkg.sv =====
// Package with widths, codes and handshake structs of the path time allocation block.
`default_nettype none
package pta_pkg;

  localparam int unsigned CoordW    = 24;              // Q13.10 coordinate
  localparam int unsigned DiffW     = CoordW + 1;      // signed coordinate difference
  localparam int unsigned MagW      = CoordW;          // |difference| < 2^24
  localparam int unsigned SqW       = 2 * MagW;        // one squared difference
  localparam int unsigned RadW      = SqW + 2;         // sum of three squares
  localparam int unsigned SegW      = RadW / 2;        // segment length
  localparam int unsigned SqrtSteps = RadW / 2;
  localparam int unsigned LenW      = 48;              // accumulated path length
  localparam int unsigned TimeW     = 32;              // Q16.16 time and speed
  localparam int unsigned FracShift = 22;              // Q.10 length to Q16.16 / Q16.16
  localparam int unsigned DivW      = LenW + FracShift;
  localparam int unsigned StepNumW  = LenW - FracShift;
  localparam int unsigned StepIters = StepNumW + FracShift;
  localparam int unsigned StatusW   = 2;

  localparam int unsigned RegW      = 32;
  localparam int unsigned AddrW     = 3;

  // Register index, taken from paddr[2].
  localparam logic REG_STOP_GAP = 1'b0;
  localparam logic [RegW-1:0] STOP_GAP_RESET = 32'd6553600;

  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_SAT  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_STOP = 2'd2;

  typedef struct packed {
    logic start;
    logic speed_mode;   // 1: length / span, 0: segment / speed
  } pta_div_req_t;

  typedef struct packed {
    logic done;
    logic ovf;          // quotient did not fit in TimeW bits
  } pta_div_rsp_t;

endpackage
`default_nettype wire

// ===== src/pta_isqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
`default_nettype none
module pta_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pta_pkg::RadW-1:0]  rad_i,
  output logic                      done_o,
  output logic [pta_pkg::SegW-1:0]  root_o
);
  import pta_pkg::*;

  localparam int unsigned CntW = $clog2(SqrtSteps + 1);
  localparam int unsigned RemW = SegW + 2;
  localparam int unsigned TryW = RemW + 2;

  logic [RadW-1:0] rad_q;
  logic [RemW-1:0] rem_q;
  logic [SegW-1:0] root_q;
  logic [CntW-1:0] cnt_q;
  logic            done_q;

  logic [TryW-1:0] cur;
  logic [TryW-1:0] trial;
  logic [TryW-1:0] diff;
  logic            ge;

  // Bring down the next two bits and try root*4+1 against the partial remainder.
  assign cur   = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        cnt_q <= CntW'(SqrtSteps);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
      root_q <= {root_q[SegW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ===== src/pta_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the speed and time step divisions.
`default_nettype none
module pta_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pta_pkg::pta_div_req_t       req_i,
  input  logic [pta_pkg::LenW-1:0]    num_i,
  input  logic [pta_pkg::TimeW-1:0]   den_i,
  output logic [pta_pkg::TimeW-1:0]   quo_o,
  output pta_pkg::pta_div_rsp_t       rsp_o
);
  import pta_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]  dvd_q;
  logic [TimeW-1:0] den_q;
  logic [TimeW-1:0] rem_q;
  logic [TimeW-1:0] quo_q;
  logic             ovf_q;
  logic [CntW-1:0]  cnt_q;
  logic             done_q;

  logic [TimeW:0]   cur;
  logic [TimeW:0]   diff;
  logic             ge;

  assign cur  = {rem_q, dvd_q[DivW-1]};
  assign diff = cur - {1'b0, den_q};
  assign ge   = (cur >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.start && (cnt_q == CntW'(1));
      if (req_i.start) begin
        // A segment fits in the low bits, so its division skips the leading zeros.
        cnt_q <= req_i.speed_mode ? CntW'(DivW) : CntW'(StepIters);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.speed_mode ? {num_i, {FracShift{1'b0}}}
                                : {num_i[StepNumW-1:0], {(DivW - StepNumW){1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? diff[TimeW-1:0] : cur[TimeW-1:0];
      quo_q <= {quo_q[TimeW-2:0], ge};
      // Any one shifted out of the top makes the quotient too wide.
      ovf_q <= ovf_q | quo_q[TimeW-1];
    end
  end

  assign quo_o     = quo_q;
  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;

endmodule
`default_nettype wire

// ===== src/path_time_allocation.sv =====
// Top level of the path time allocation block: sequencer, squaring unit and state.
//
// Channel  Dir  Handshake                 Beat contents
// in       in   in_valid_i / in_stall_o   pos_x, pos_y, pos_z, stamp, observed, path_end
// out      out  out_valid_o / out_stall_i point_time, status, end_mark
// cfg      in   APB psel/penable/pwrite   stop_gap at byte address 0
//
// One point is processed at a time; in_stall_o is high from acceptance until its result is
// loaded into the output register, which may still be waiting for the sink.
// The first point of a path runs ST_DISP and ST_WB; a predicted point at zero speed runs
// ST_DISP, ST_PRED and ST_WB. An observed segment squares each axis and sums in ST_SQR,
// then takes the square root in ST_SQRT. A predicted segment adds the divider in ST_STEP;
// the first predicted point also runs the speed division in ST_SPD. No clearing pass follows reset.
`default_nettype none
`include "path_time_allocation_macros.svh"
module path_time_allocation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pta_pkg::CoordW-1:0]  pos_x_i,
  input  logic signed [pta_pkg::CoordW-1:0]  pos_y_i,
  input  logic signed [pta_pkg::CoordW-1:0]  pos_z_i,
  input  logic [pta_pkg::TimeW-1:0]          stamp_i,
  input  logic                               observed_i,
  input  logic                               path_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pta_pkg::TimeW-1:0]          point_time_o,
  output logic [pta_pkg::StatusW-1:0]        status_o,
  output logic                               end_mark_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pta_pkg::AddrW-1:0]          paddr,
  input  logic [pta_pkg::RegW-1:0]           pwdata,
  output logic [pta_pkg::RegW-1:0]           prdata,
  output logic                               pready
);
  import pta_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_SPD  = 3'd2;
  localparam logic [2:0] ST_PRED = 3'd3;
  localparam logic [2:0] ST_SQR  = 3'd4;
  localparam logic [2:0] ST_SQRT = 3'd5;
  localparam logic [2:0] ST_STEP = 3'd6;
  localparam logic [2:0] ST_WB   = 3'd7;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OBS  = 2'd1;
  localparam logic [1:0] PH_PRED = 2'd2;

  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Y   = 2'd1;
  localparam logic [1:0] AX_Z   = 2'd2;
  localparam logic [1:0] AX_SUM = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] ph_q;
  logic [1:0] sq_cnt_q;

  logic [RegW-1:0]   stop_gap_q;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic [TimeW-1:0]  prev_time_q, first_time_q, speed_q;
  logic [LenW-1:0]   len_q;
  logic              span_zero_q;

  logic signed [CoordW-1:0] x_q, y_q, z_q;
  logic [TimeW-1:0]  stamp_q;
  logic              obs_q, end_q;

  logic [SqW-1:0]    prod_q;
  logic [RadW-1:0]   acc_q;
  logic [TimeW-1:0]  res_time_q;
  logic [StatusW-1:0] res_status_q;

  logic              out_valid_q;
  logic [TimeW-1:0]  out_time_q;
  logic [StatusW-1:0] out_status_q;
  logic              out_end_q;

  logic              in_accept;
  logic              out_free;
  logic              cfg_wr;

  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]  mag_full;
  logic [MagW-1:0]   mag;
  logic [RadW-1:0]   acc_sum;

  logic              sqrt_start;
  logic              sqrt_done;
  logic [SegW-1:0]   seg;
  logic [LenW:0]     len_sum;
  logic [LenW-1:0]   len_sat;

  pta_div_req_t      div_req;
  pta_div_rsp_t      div_rsp;
  logic [LenW-1:0]   div_num;
  logic [TimeW-1:0]  div_den;
  logic [TimeW-1:0]  div_quo;
  logic [TimeW-1:0]  span;
  logic              span_pos;

  logic [TimeW-1:0]  inc;
  logic [TimeW:0]    time_sum;
  logic              time_sat;
  logic [TimeW-1:0]  step_time;
  logic [StatusW-1:0] step_status;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STOP_GAP);
  assign prdata = (paddr[2] == REG_STOP_GAP) ? stop_gap_q : '0;

  // Squaring unit: one axis per cycle through a single multiplier.
  always_comb begin
    case (sq_cnt_q)
      AX_X:    diff = DiffW'(x_q) - DiffW'(prev_x_q);
      AX_Y:    diff = DiffW'(y_q) - DiffW'(prev_y_q);
      AX_Z:    diff = DiffW'(z_q) - DiffW'(prev_z_q);
      default: diff = '0;
    endcase
  end

  assign mag_full = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign mag      = mag_full[MagW-1:0];
  assign acc_sum  = acc_q + {2'b00, prod_q};

  assign len_sum = {1'b0, len_q} + (LenW + 1)'(seg);
  assign len_sat = len_sum[LenW] ? '1 : len_sum[LenW-1:0];

  assign span     = prev_time_q - first_time_q;
  assign span_pos = (prev_time_q > first_time_q);
  assign div_num  = (state_q == ST_DISP) ? len_q : LenW'(seg);
  assign div_den  = (state_q == ST_DISP) ? span : speed_q;

  // Time step adder, fed by stop_gap at zero speed or by the divider.
  assign inc         = (state_q == ST_STEP) ? div_quo : stop_gap_q;
  assign time_sum    = {1'b0, prev_time_q} + {1'b0, inc};
  assign time_sat    = time_sum[TimeW] || ((state_q == ST_STEP) && div_rsp.ovf);
  assign step_time   = time_sat ? '1 : time_sum[TimeW-1:0];
  assign step_status = time_sat ? STATUS_SAT : (span_zero_q ? STATUS_STOP : STATUS_OK);

  always_comb begin
    state_d            = state_q;
    sqrt_start         = 1'b0;
    div_req.start      = 1'b0;
    div_req.speed_mode = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_DISP;
      end
      ST_DISP: begin
        case (ph_q)
          PH_IDLE: state_d = ST_WB;
          PH_OBS: begin
            if (obs_q) begin
              state_d = ST_SQR;
            end else if (span_pos) begin
              div_req.start      = 1'b1;
              div_req.speed_mode = 1'b1;
              state_d            = ST_SPD;
            end else begin
              state_d = ST_PRED;
            end
          end
          default: state_d = ST_PRED;
        endcase
      end
      ST_SPD: begin
        if (div_rsp.done) state_d = ST_PRED;
      end
      ST_PRED: begin
        state_d = (speed_q == '0) ? ST_WB : ST_SQR;
      end
      ST_SQR: begin
        if (sq_cnt_q == AX_SUM) begin
          sqrt_start = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          if (ph_q == PH_OBS) begin
            state_d = ST_WB;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        if (div_rsp.done) state_d = ST_WB;
      end
      ST_WB: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  pta_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (acc_sum),
    .done_o  (sqrt_done),
    .root_o  (seg)
  );

  pta_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (div_quo),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ph_q         <= PH_IDLE;
      sq_cnt_q     <= AX_X;
      stop_gap_q   <= STOP_GAP_RESET;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_z_q     <= '0;
      prev_time_q  <= '0;
      first_time_q <= '0;
      speed_q      <= '0;
      len_q        <= '0;
      span_zero_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) stop_gap_q <= pwdata;
      if ((state_q == ST_WB) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_DISP: begin
          if (ph_q == PH_IDLE) begin
            if (obs_q) begin
              first_time_q <= stamp_q;
              len_q        <= '0;
              ph_q         <= PH_OBS;
            end else begin
              speed_q     <= '0;
              span_zero_q <= 1'b1;
              ph_q        <= PH_PRED;
            end
          end else if ((ph_q == PH_OBS) && !obs_q && !span_pos) begin
            // Zero or backward observed span: the path counts as stopped.
            speed_q     <= '0;
            span_zero_q <= 1'b1;
            ph_q        <= PH_PRED;
          end
        end
        ST_SPD: begin
          if (div_rsp.done) begin
            speed_q     <= div_rsp.ovf ? '1 : div_quo;
            span_zero_q <= 1'b0;
            ph_q        <= PH_PRED;
          end
        end
        ST_SQR: begin
          sq_cnt_q <= sq_cnt_q + 1'b1;
        end
        ST_SQRT: begin
          if (sqrt_done && (ph_q == PH_OBS)) len_q <= len_sat;
        end
        ST_WB: begin
          if (out_free) begin
            // The last beat of a path returns the path state to reset.
            prev_x_q    <= end_q ? '0 : x_q;
            prev_y_q    <= end_q ? '0 : y_q;
            prev_z_q    <= end_q ? '0 : z_q;
            prev_time_q <= end_q ? '0 : res_time_q;
            if (end_q) begin
              first_time_q <= '0;
              speed_q      <= '0;
              len_q        <= '0;
              span_zero_q  <= 1'b0;
              ph_q         <= PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          x_q     <= pos_x_i;
          y_q     <= pos_y_i;
          z_q     <= pos_z_i;
          stamp_q <= stamp_i;
          obs_q   <= observed_i;
          end_q   <= path_end_i;
        end
      end
      ST_DISP: begin
        if (ph_q == PH_IDLE) begin
          // A path that opens with a predicted point starts at time zero.
          res_time_q   <= obs_q ? stamp_q : '0;
          res_status_q <= obs_q ? STATUS_OK : STATUS_STOP;
        end
      end
      ST_PRED: begin
        if (speed_q == '0) begin
          res_time_q   <= step_time;
          res_status_q <= step_status;
        end
      end
      ST_SQR: begin
        prod_q <= mag * mag;
        acc_q  <= (sq_cnt_q == AX_X) ? '0 : acc_sum;
      end
      ST_SQRT: begin
        if (sqrt_done && (ph_q == PH_OBS)) begin
          res_time_q   <= stamp_q;
          res_status_q <= STATUS_OK;
        end
      end
      ST_STEP: begin
        if (div_rsp.done) begin
          res_time_q   <= step_time;
          res_status_q <= step_status;
        end
      end
      ST_WB: begin
        if (out_free) begin
          out_time_q   <= res_time_q;
          out_status_q <= res_status_q;
          out_end_q    <= end_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign point_time_o = out_time_q;
  assign status_o     = out_status_q;
  assign end_mark_o   = out_end_q;

  `PTA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_accept, in_stall_o)
  `PTA_ASSERT_IMP(a_step_speed_nonzero, clk_i, rst_ni, state_q == ST_STEP, speed_q != '0)
  `PTA_ASSERT_IMP(a_div_done_expected, clk_i, rst_ni, div_rsp.done, (state_q == ST_SPD) || (state_q == ST_STEP))
  `PTA_ASSERT_IMP(a_idle_path_clear, clk_i, rst_ni, ph_q == PH_IDLE, !span_zero_q && (speed_q == '0) && (len_q == '0))

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for path_time_allocation: directed and random paths checked against a point time predictor.
module tb;
  import pta_pkg::*;

  localparam int unsigned WatchLimit = 4000;
  localparam logic [AddrW-1:0] STOP_GAP_ADDR = {REG_STOP_GAP, 2'b00};

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [TimeW-1:0]         stamp;
    logic                     observed;
    logic                     path_end;
  } point_t;

  typedef struct {
    logic [TimeW-1:0]   point_time;
    logic [StatusW-1:0] status;
    logic               end_mark;
  } timing_t;

  typedef enum logic [1:0] {AWAIT_FIRST, OBSERVING, PREDICTING} path_phase_e;

  class timing_board;
    logic [TimeW-1:0]         stop_gap;
    logic signed [CoordW-1:0] last_x, last_y, last_z;
    logic [TimeW-1:0]         last_time, start_time, speed;
    logic [LenW-1:0]          length_sum;
    path_phase_e              phase;
    bit                       stopped;
    timing_t                  due_times[$];
    int unsigned              mismatches;
    int unsigned              checked;

    function new();
      stop_gap = STOP_GAP_RESET;
      mismatches = 0;
      checked = 0;
      clear_path();
    endfunction

    function void clear_path();
      last_x = '0;
      last_y = '0;
      last_z = '0;
      last_time = '0;
      start_time = '0;
      speed = '0;
      length_sum = '0;
      phase = AWAIT_FIRST;
      stopped = 1'b0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    // Largest r with r*r <= v, built one bit at a time from the top.
    function longint unsigned floor_root(longint unsigned v);
      longint unsigned r, c;
      int i;
      r = 0;
      for (i = SegW; i >= 0; i--) begin
        c = r | (64'd1 << i);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    function longint unsigned segment(point_t p);
      longint dx, dy, dz;
      dx = longint'(p.x) - longint'(last_x);
      dy = longint'(p.y) - longint'(last_y);
      dz = longint'(p.z) - longint'(last_z);
      return floor_root(longint'(dx * dx + dy * dy + dz * dz));
    endfunction

    function logic [TimeW-1:0] speed_of(logic [LenW-1:0] len, logic [TimeW-1:0] span);
      logic [DivW-1:0] q;
      q = {len, {FracShift{1'b0}}} / DivW'(span);
      return (q > DivW'({TimeW{1'b1}})) ? {TimeW{1'b1}} : q[TimeW-1:0];
    endfunction

    function void note_point(point_t p);
      timing_t r;
      longint unsigned step, total;
      r.status = STATUS_OK;
      r.end_mark = p.path_end;
      if (phase == AWAIT_FIRST) begin
        if (p.observed) begin
          r.point_time = p.stamp;
          start_time = p.stamp;
          length_sum = '0;
          phase = OBSERVING;
        end else begin
          r.point_time = '0;
          speed = '0;
          stopped = 1'b1;
          r.status = STATUS_STOP;
          phase = PREDICTING;
        end
      end else if (phase == OBSERVING && p.observed) begin
        total = 64'(length_sum) + segment(p);
        length_sum = (total >> LenW != 0) ? {LenW{1'b1}} : total[LenW-1:0];
        r.point_time = p.stamp;
      end else begin
        // The first predicted point fixes the speed for the rest of the path.
        if (phase == OBSERVING) begin
          if (last_time > start_time) begin
            speed = speed_of(length_sum, last_time - start_time);
            stopped = 1'b0;
          end else begin
            speed = '0;
            stopped = 1'b1;
          end
          phase = PREDICTING;
        end
        if (speed == 0) step = 64'(stop_gap);
        else step = (segment(p) << FracShift) / 64'(speed);
        total = 64'(last_time) + step;
        if (total > 64'hFFFF_FFFF) begin
          r.point_time = {TimeW{1'b1}};
          r.status = STATUS_SAT;
        end else begin
          r.point_time = total[TimeW-1:0];
          r.status = stopped ? STATUS_STOP : STATUS_OK;
        end
      end
      last_time = r.point_time;
      last_x = p.x;
      last_y = p.y;
      last_z = p.z;
      due_times = {due_times, r};
      if (p.path_end) clear_path();
    endfunction

    function void check_result(timing_t got);
      timing_t want;
      checked++;
      if (due_times.size() == 0) begin
        flag($sformatf("tb: result %0d arrived with nothing expected: time %h status %0d end %0b",
                       checked, got.point_time, got.status, got.end_mark));
        return;
      end
      want = due_times[0];
      due_times.delete(0);
      if (got.point_time !== want.point_time || got.status !== want.status ||
          got.end_mark !== want.end_mark)
        flag($sformatf("tb: result %0d: time %h/%h status %0d/%0d end %0b/%0b (expected/actual)",
                       checked, want.point_time, got.point_time, want.status, got.status,
                       want.end_mark, got.end_mark));
    endfunction

    function void close_out();
      if (due_times.size() != 0)
        flag($sformatf("tb: %0d results never arrived", due_times.size()));
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] pos_x = '0;
  logic signed [CoordW-1:0] pos_y = '0;
  logic signed [CoordW-1:0] pos_z = '0;
  logic [TimeW-1:0]         stamp = '0;
  logic                     observed = 1'b0;
  logic                     path_end = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  logic [TimeW-1:0]         point_time_o;
  logic [StatusW-1:0]       status_o;
  logic                     end_mark_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [AddrW-1:0]         paddr = '0;
  logic [RegW-1:0]          pwdata = '0;
  logic [RegW-1:0]          prdata;
  logic                     pready;

  timing_board board = new();
  bit          steady = 1'b0;
  int unsigned sent = 0;
  int unsigned quiet_cycles = 0;

  path_time_allocation dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .stamp_i      (stamp),
    .observed_i   (observed),
    .path_end_i   (path_end),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .point_time_o (point_time_o),
    .status_o     (status_o),
    .end_mark_o   (end_mark_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < 13);
  endfunction

  always @(negedge clk_i) begin
    out_stall <= take_break();
  end

  // Beats are taken at the rising edge; the input is noted before the result is checked.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && !in_stall_o)
        board.note_point('{x: pos_x, y: pos_y, z: pos_z, stamp: stamp,
                           observed: observed, path_end: path_end});
      if (out_valid_o && !out_stall)
        board.check_result('{point_time: point_time_o, status: status_o,
                             end_mark: end_mark_o});
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_point(point_t p);
    @(negedge clk_i);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    pos_x <= p.x;
    pos_y <= p.y;
    pos_z <= p.z;
    stamp <= p.stamp;
    observed <= p.observed;
    path_end <= p.path_end;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (board.due_times.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_stop_gap(logic [RegW-1:0] value);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= STOP_GAP_ADDR;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.stop_gap = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic point_t pt(int x, int y, int z, logic [TimeW-1:0] t, bit obs, bit last);
    point_t p;
    p.x = CoordW'(x);
    p.y = CoordW'(y);
    p.z = CoordW'(z);
    p.stamp = t;
    p.observed = obs;
    p.path_end = last;
    return p;
  endfunction

  task automatic run_directed();
    int hi, lo;
    hi = 8388607;
    lo = -8388608;
    send_point(pt(0, 0, 0, 32'h0, 1, 0));
    send_point(pt(hi, hi, hi, 32'h1_0000, 1, 0));
    send_point(pt(lo, lo, lo, 32'h3_0000, 1, 0));
    send_point(pt(0, 0, 0, 32'h0, 0, 0));
    send_point(pt(1, 0, 0, 32'h0, 0, 1));
    // Path that opens with a predicted point.
    send_point(pt(5, 5, 5, 32'h0, 0, 0));
    send_point(pt(6, 5, 5, 32'h0, 0, 1));
    // Zero observed span.
    send_point(pt(10, 0, 0, 32'd500, 1, 0));
    send_point(pt(20, 0, 0, 32'd500, 1, 0));
    send_point(pt(30, 0, 0, 32'h0, 0, 1));
    // Backward observed span.
    send_point(pt(0, 0, 0, 32'd900, 1, 0));
    send_point(pt(4096, 0, 0, 32'd400, 1, 0));
    send_point(pt(0, 0, 0, 32'h0, 0, 1));
    // Stationary observation over a nonzero span.
    send_point(pt(7, 7, 7, 32'h0, 1, 0));
    send_point(pt(7, 7, 7, 32'h2_8000, 1, 0));
    send_point(pt(-7, 0, 0, 32'h0, 0, 1));
    // An observed point after prediction began is handled as predicted.
    send_point(pt(0, 0, 0, 32'h1_0000, 1, 0));
    send_point(pt(1024, 0, 0, 32'h2_0000, 1, 0));
    send_point(pt(2048, 0, 0, 32'h0, 0, 0));
    send_point(pt(3072, 0, 0, 32'hFFFF_FFFF, 1, 1));
    // Time saturation, first through the stop gap, then through a long jump.
    send_point(pt(0, 0, 0, 32'hFFFF_FF00, 1, 0));
    send_point(pt(0, 0, 0, 32'h0, 0, 1));
    send_point(pt(0, 0, 0, 32'hFFFF_0000, 1, 0));
    send_point(pt(1, 0, 0, 32'hFFFF_0001, 1, 0));
    send_point(pt(hi, hi, hi, 32'h0, 0, 1));
    send_point(pt(3, 2, 1, 32'h1234, 1, 1));
  endtask

  task automatic send_noise();
    point_t p;
    p.x = CoordW'($urandom);
    p.y = CoordW'($urandom);
    p.z = CoordW'($urandom);
    p.stamp = $urandom;
    p.observed = $urandom_range(0, 1);
    p.path_end = ($urandom_range(0, 3) == 0);
    send_point(p);
  endtask

  task automatic run_path();
    point_t p;
    int unsigned n_obs, n_pred, n_all, span_kind, reach, i;
    logic [TimeW-1:0] t;
    n_obs = ($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 5);
    n_pred = $urandom_range(0, 6);
    if (n_obs + n_pred == 0) n_pred = 1;
    n_all = n_obs + n_pred;
    span_kind = $urandom_range(0, 99);
    reach = 1 << $urandom_range(4, 14);
    t = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h4000_0000);
    p.x = CoordW'($urandom);
    p.y = CoordW'($urandom);
    p.z = CoordW'($urandom);
    for (i = 0; i < n_all; i++) begin
      if (i != 0) begin
        p.x = p.x + CoordW'(int'($urandom_range(0, 2 * reach)) - int'(reach));
        p.y = p.y + CoordW'(int'($urandom_range(0, 2 * reach)) - int'(reach));
        p.z = p.z + CoordW'(int'($urandom_range(0, 2 * reach)) - int'(reach));
        if (span_kind < 10) t = t;
        else if (span_kind < 16) t = t - $urandom_range(1, 32'h4_0000);
        else t = t + $urandom_range(1, 32'h4_0000);
      end
      p.observed = (i < n_obs) || ($urandom_range(0, 99) < 5);
      p.stamp = (i < n_obs) ? t : $urandom;
      p.path_end = (i == n_all - 1);
      send_point(p);
    end
  endtask

  task automatic run_phase(int unsigned count);
    int unsigned goal;
    goal = sent + count;
    while (sent < goal) begin
      if ($urandom_range(0, 99) < 85) run_path();
      else send_noise();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;

    run_directed();
    write_stop_gap('0);
    run_phase(220);
    write_stop_gap('1);
    run_phase(220);
    steady = 1'b1;
    write_stop_gap(32'd1);
    run_phase(220);
    steady = 1'b0;
    write_stop_gap($urandom);
    run_phase(220);
    write_stop_gap(STOP_GAP_RESET);
    run_phase(220);

    drain();
    repeat (200) @(posedge clk_i);
    board.close_out();
    if (board.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
